/* rtl/xor_checked_frame_validator_core_assert.svh */
// Assertion macros for the frame validator.
// Each check samples on i_clk and is ignored while i_rst_n is low.
`ifndef XOR_CHECKED_FRAME_VALIDATOR_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_VALIDATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define XFV_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("frame validator check failed");
`define XFV_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("frame validator forbidden condition seen");
`else
`define XFV_ASSERT(label, prop)
`define XFV_NEVER(label, expr)
`endif

`endif

/* rtl/xfv_pkg.sv */
package xfv_pkg;

    localparam int unsigned MaxFrameLen = 255;
    // r_count is 8 bits wide, so the limit never passes 255
    localparam int unsigned LenLimit    = (MaxFrameLen < 255) ? MaxFrameLen : 255;
    localparam int unsigned MinFrameLen = 6;
    localparam int unsigned TrailerLen  = 5;
    localparam int unsigned SumBias     = 32'h0000_00AA;

    localparam int unsigned AddrWidth = 5;

    // register indexes
    localparam logic [2:0] REG_HEADER    = 3'd0;
    localparam logic [2:0] REG_FOOTER    = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_FOOT_LEN  = 3'd3;
    localparam logic [2:0] REG_WHEEL_LEN = 3'd4;
    localparam logic [2:0] REG_UPD_LEN   = 3'd5;

    // frame kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FOOT   = 2'd1;
    localparam logic [1:0] KIND_WHEEL  = 2'd2;
    localparam logic [1:0] KIND_UPDATE = 2'd3;

    // verdicts
    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_BAD_LEN  = 3'd1;
    localparam logic [2:0] VERDICT_BAD_HEAD = 3'd2;
    localparam logic [2:0] VERDICT_BAD_FOOT = 3'd3;
    localparam logic [2:0] VERDICT_BAD_SUM  = 3'd4;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] footer_value;
        logic [7:0] update_command_threshold;
        logic [7:0] foot_frame_length;
        logic [7:0] wheel_frame_length;
        logic [7:0] update_frame_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [2:0]  verdict;
        logic [31:0] computed_sum;
    } t_result;

endpackage

/* rtl/xfv_regs.sv */
module xfv_regs
    import xfv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[AddrWidth-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value             <= 8'd0;
            r_cfg.footer_value             <= 8'd0;
            r_cfg.update_command_threshold <= 8'd255;
            r_cfg.foot_frame_length        <= 8'd0;
            r_cfg.wheel_frame_length       <= 8'd0;
            r_cfg.update_frame_length      <= 8'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER:    r_cfg.header_value             <= pwdata[7:0];
                REG_FOOTER:    r_cfg.footer_value             <= pwdata[7:0];
                REG_THRESHOLD: r_cfg.update_command_threshold <= pwdata[7:0];
                REG_FOOT_LEN:  r_cfg.foot_frame_length        <= pwdata[7:0];
                REG_WHEEL_LEN: r_cfg.wheel_frame_length       <= pwdata[7:0];
                REG_UPD_LEN:   r_cfg.update_frame_length      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER:    prdata = {24'd0, r_cfg.header_value};
            REG_FOOTER:    prdata = {24'd0, r_cfg.footer_value};
            REG_THRESHOLD: prdata = {24'd0, r_cfg.update_command_threshold};
            REG_FOOT_LEN:  prdata = {24'd0, r_cfg.foot_frame_length};
            REG_WHEEL_LEN: prdata = {24'd0, r_cfg.wheel_frame_length};
            REG_UPD_LEN:   prdata = {24'd0, r_cfg.update_frame_length};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/xfv_frame.sv */
module xfv_frame
    import xfv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  r_trail [TrailerLen];
    logic [31:0] r_acc;
    logic [23:0] r_part;
    logic [7:0]  r_count;
    logic        r_ovf;
    logic [7:0]  r_first;
    logic [7:0]  r_cmd;

    logic [7:0]  n_trail [TrailerLen];
    logic [31:0] n_acc;
    logic [23:0] n_part;
    logic [7:0]  n_count;
    logic        n_ovf;
    logic [7:0]  n_first;
    logic [7:0]  n_cmd;

    logic [1:0]  slot;
    logic [7:0]  tail;
    logic [31:0] sum;
    logic [31:0] field;
    logic [1:0]  kind;
    logic [2:0]  verdict;

    assign slot = 2'(r_count - 8'(TrailerLen));

    always_comb begin
        n_trail = r_trail;
        n_acc   = r_acc;
        n_part  = r_part;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_first = r_first;
        n_cmd   = r_cmd;
        if (!r_ovf) begin
            if (32'(r_count) >= LenLimit) begin
                n_ovf = 1'b1;
            end else begin
                // the byte leaving the trailer window joins the checksum
                if (32'(r_count) >= TrailerLen) begin
                    if (slot == 2'd3) begin
                        n_acc  = r_acc ^ {r_trail[TrailerLen-1], r_part};
                        n_part = 24'd0;
                    end else begin
                        n_part = r_part | ({16'd0, r_trail[TrailerLen-1]} << {slot, 3'd0});
                    end
                end
                for (int i = TrailerLen - 1; i > 0; i--) begin
                    n_trail[i] = r_trail[i-1];
                end
                n_trail[0] = i_byte;
                if (r_count == 8'd0) begin
                    n_first = i_byte;
                end else if (r_count == 8'd1) begin
                    n_cmd = i_byte;
                end
                n_count = r_count + 8'd1;
            end
        end
    end

    assign tail  = n_part[7:0] ^ n_part[15:8] ^ n_part[23:16];
    assign sum   = (n_acc ^ {24'd0, tail}) + SumBias;
    assign field = {n_trail[1], n_trail[2], n_trail[3], n_trail[4]};

    always_comb begin
        kind = KIND_NONE;
        if (n_ovf || 32'(n_count) < MinFrameLen) begin
            kind = KIND_NONE;
        end else if (n_cmd < i_cfg.update_command_threshold) begin
            if (n_count == i_cfg.foot_frame_length) begin
                kind = KIND_FOOT;
            end else if (n_count == i_cfg.wheel_frame_length) begin
                kind = KIND_WHEEL;
            end
        end else if (n_count == i_cfg.update_frame_length) begin
            kind = KIND_UPDATE;
        end
    end

    always_comb begin
        if (kind == KIND_NONE) begin
            verdict = VERDICT_BAD_LEN;
        end else if (n_first != i_cfg.header_value) begin
            verdict = VERDICT_BAD_HEAD;
        end else if (n_trail[0] != i_cfg.footer_value) begin
            verdict = VERDICT_BAD_FOOT;
        end else if (field != sum) begin
            verdict = VERDICT_BAD_SUM;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    // clear the frame state once the closing byte is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end)) begin
            for (int i = 0; i < TrailerLen; i++) begin
                r_trail[i] <= 8'd0;
            end
            r_acc   <= 32'd0;
            r_part  <= 24'd0;
            r_count <= 8'd0;
            r_ovf   <= 1'b0;
            r_first <= 8'd0;
            r_cmd   <= 8'd0;
        end else if (i_take) begin
            r_trail <= n_trail;
            r_acc   <= n_acc;
            r_part  <= n_part;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_first <= n_first;
            r_cmd   <= n_cmd;
        end
    end

    assign o_res_valid       = i_take & i_end;
    assign o_res.frame_kind  = kind;
    assign o_res.verdict     = verdict;
    assign o_res.computed_sum = sum;

endmodule

/* rtl/xor_checked_frame_validator_core.sv */
// Frame validator: checks header, footer, length and XOR checksum of byte frames.
// Input channel: one frame byte per request (i_frame_byte, i_frame_end marks the
// last byte), taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: one verdict per frame (o_frame_kind, o_verdict, o_computed_sum),
// taken at an edge with o_out_valid high and i_out_stall low.
// Throughput: one byte per cycle while o_in_stall is low; the per-byte update and
// the verdict logic are combinational, between frame state and result register.
// The verdict is registered in the output register, or in the skid register.
// A two-entry result buffer (output register plus skid register) lets bytes keep
// flowing while a verdict waits; o_in_stall rises only when both entries are
// full, i.e. after two verdicts have been held back by i_out_stall.
// Bytes that do not close a frame produce no result.
// Configuration goes through the APB port (registers at byte address 4*index),
// and the user is to change it only while no frame is in progress and no verdict
// is pending; the block does not enforce this. Reset (synchronous, i_rst_n low)
// restores register defaults, clears the frame state, empties the result buffer.
`include "xor_checked_frame_validator_core_assert.svh"

module xor_checked_frame_validator_core
    import xfv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_frame_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_frame_kind,
    output logic [2:0]           o_verdict,
    output logic [31:0]          o_computed_sum
);

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    take;
    logic    out_free;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    xfv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign take = i_in_valid & ~r_skid_valid;

    xfv_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_frame_byte),
        .i_end       (i_frame_end),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // drain the skid entry first; no new request arrives while it is full
            r_out_valid  <= r_skid_valid | res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_frame_kind   = r_out.frame_kind;
    assign o_verdict      = r_out.verdict;
    assign o_computed_sum = r_out.computed_sum;

    `XFV_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    `XFV_ASSERT(a_held_verdict_kept, (r_out_valid && i_out_stall) |=> r_out_valid)
    `XFV_ASSERT(a_full_buffer_blocks, (r_skid_valid && i_out_stall) |=> !res_valid)
    `XFV_ASSERT(a_kind_matches_verdict,
        o_out_valid |-> ((o_frame_kind == KIND_NONE) == (o_verdict == VERDICT_BAD_LEN)))
    `XFV_NEVER(a_verdict_range, o_out_valid && (o_verdict > VERDICT_BAD_SUM))

endmodule

/* sim/testbench.sv */
module testbench;
    import xfv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QuietLimit = 2000;
    localparam int unsigned PhaseBytes = 36;

    typedef enum int {FLAW_NONE, FLAW_HEAD, FLAW_FOOT, FLAW_SUM} t_frame_flaw;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_body_fill;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           frame_byte = '0;
    logic                 frame_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           frame_kind;
    logic [2:0]           verdict;
    logic [31:0]          computed_sum;

    xor_checked_frame_validator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_frame_byte   (frame_byte),
        .i_frame_end    (frame_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_frame_kind   (frame_kind),
        .o_verdict      (verdict),
        .o_computed_sum (computed_sum)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the validator: configuration and per-frame state
    t_cfg        cfg_model;
    logic [7:0]  tail_bytes [5];
    logic [31:0] word_xor;
    logic [23:0] part_word;
    int unsigned byte_total;
    logic        too_long;
    logic [7:0]  head_byte;
    logic [7:0]  cmd_byte;

    t_result     expected_verdicts [$];
    logic [7:0]  frame_buf [$];
    logic        bursty = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    t_result     want_res;

    task automatic clear_frame_model();
        for (int i = 0; i < 5; i++) tail_bytes[i] = '0;
        word_xor   = '0;
        part_word  = '0;
        byte_total = 0;
        too_long   = 1'b0;
        head_byte  = '0;
        cmd_byte   = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned q;
        logic [7:0]  low_xor;
        logic [31:0] field;
        t_result     res;
        if (!too_long) begin
            if (byte_total >= LenLimit) begin
                too_long = 1'b1;
            end else begin
                if (byte_total >= TrailerLen) begin
                    q = (byte_total - TrailerLen) % 4;
                    if (q == 3) begin
                        word_xor ^= {tail_bytes[4], part_word};
                        part_word = '0;
                    end else begin
                        part_word |= 24'(tail_bytes[4]) << (8 * q);
                    end
                end
                for (int i = 4; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
                tail_bytes[0] = b;
                if (byte_total == 0) head_byte = b;
                else if (byte_total == 1) cmd_byte = b;
                byte_total++;
            end
        end
        if (last) begin
            low_xor = part_word[7:0] ^ part_word[15:8] ^ part_word[23:16];
            res.computed_sum = (word_xor ^ {24'd0, low_xor}) + 32'(SumBias);
            res.frame_kind = KIND_NONE;
            if (too_long || byte_total < MinFrameLen || byte_total > LenLimit) begin
                res.frame_kind = KIND_NONE;
            end else if (cmd_byte < cfg_model.update_command_threshold) begin
                if (byte_total == cfg_model.foot_frame_length) res.frame_kind = KIND_FOOT;
                else if (byte_total == cfg_model.wheel_frame_length) res.frame_kind = KIND_WHEEL;
            end else if (byte_total == cfg_model.update_frame_length) begin
                res.frame_kind = KIND_UPDATE;
            end
            field = {tail_bytes[1], tail_bytes[2], tail_bytes[3], tail_bytes[4]};
            if (res.frame_kind == KIND_NONE) res.verdict = VERDICT_BAD_LEN;
            else if (head_byte != cfg_model.header_value) res.verdict = VERDICT_BAD_HEAD;
            else if (tail_bytes[0] != cfg_model.footer_value) res.verdict = VERDICT_BAD_FOOT;
            else if (field != res.computed_sum) res.verdict = VERDICT_BAD_SUM;
            else res.verdict = VERDICT_OK;
            expected_verdicts.push_back(res);
            clear_frame_model();
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'({idx, 2'b00});
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEADER:    cfg_model.header_value = val;
            REG_FOOTER:    cfg_model.footer_value = val;
            REG_THRESHOLD: cfg_model.update_command_threshold = val;
            REG_FOOT_LEN:  cfg_model.foot_frame_length = val;
            REG_WHEEL_LEN: cfg_model.wheel_frame_length = val;
            REG_UPD_LEN:   cfg_model.update_frame_length = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [7:0] hdr, input logic [7:0] ftr,
                                input logic [7:0] thr, input logic [7:0] foot,
                                input logic [7:0] wheel, input logic [7:0] upd);
        write_reg(REG_HEADER, hdr);
        write_reg(REG_FOOTER, ftr);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FOOT_LEN, foot);
        write_reg(REG_WHEEL_LEN, wheel);
        write_reg(REG_UPD_LEN, upd);
    endtask

    // one request on the byte channel; the caller must not let time pass in between
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = bursty ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        frame_end  <= last;
        do @(posedge i_clk); while (in_stall);
        bytes_sent++;
        predict_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic await_results();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // let the pipeline settle before touching the registers
    task automatic await_idle();
        await_results();
        repeat (4) @(posedge i_clk);
    endtask

    // checksum of the bytes ahead of the trailer, as the sender would compute it
    function automatic logic [31:0] frame_sum(input int unsigned n);
        logic [31:0] acc;
        logic [7:0]  lo;
        acc = '0;
        lo  = '0;
        for (int unsigned i = 0; i < n; i++) begin
            if (i / 4 < n / 4) acc ^= 32'(frame_buf[i]) << (8 * (i % 4));
            else lo ^= frame_buf[i];
        end
        return (acc ^ {24'd0, lo}) + 32'(SumBias);
    endfunction

    task automatic build_frame(input int unsigned len, input logic [7:0] cmd,
                               input t_frame_flaw flaw, input t_body_fill fill);
        logic [31:0] sum;
        logic [7:0]  flip;
        frame_buf.delete();
        for (int unsigned i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: frame_buf.push_back(8'h00);
                FILL_ONES: frame_buf.push_back(8'hFF);
                default:   frame_buf.push_back(8'($urandom));
            endcase
        end
        flip = 8'(1 << $urandom_range(0, 7));
        if (len >= 1) frame_buf[0] = cfg_model.header_value;
        if (len >= 2) frame_buf[1] = cmd;
        if (len >= 6) begin
            sum = frame_sum(len - 5);
            for (int unsigned i = 0; i < 4; i++) frame_buf[len-5+i] = sum[8*i +: 8];
            if (flaw == FLAW_SUM) frame_buf[len-5+$urandom_range(0, 3)] ^= flip;
        end
        if (len >= 1) begin
            frame_buf[len-1] = cfg_model.footer_value;
            if (flaw == FLAW_HEAD) frame_buf[0] ^= flip;
            if (flaw == FLAW_FOOT) frame_buf[len-1] ^= flip;
        end
    endtask

    task automatic test_reset_defaults();
        bursty = 1'b0;
        build_frame(6, 8'h00, FLAW_NONE, FILL_RANDOM);
        send_frame();
        bursty = 1'b1;
        build_frame(5, 8'hFE, FLAW_NONE, FILL_RANDOM);
        send_frame();
        await_idle();
    endtask

    task automatic test_directed_frames();
        write_config(8'hA5, 8'h5A, 8'h80, 8'd6, 8'd255, 8'd9);
        bursty = 1'b1;
        build_frame(6, 8'h00, FLAW_NONE, FILL_ZERO);
        send_frame();
        build_frame(6, 8'h7F, FLAW_NONE, FILL_ONES);
        send_frame();
        build_frame(9, 8'h80, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(9, 8'hFF, FLAW_NONE, FILL_ONES);
        send_frame();
        // update command at a foot length
        build_frame(6, 8'hC0, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(7, 8'h00, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(6, 8'h01, FLAW_HEAD, FILL_RANDOM);
        send_frame();
        build_frame(6, 8'h02, FLAW_FOOT, FILL_RANDOM);
        send_frame();
        build_frame(9, 8'hA0, FLAW_SUM, FILL_RANDOM);
        send_frame();
        build_frame(5, 8'h00, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(1, 8'h00, FLAW_NONE, FILL_RANDOM);
        send_frame();
        bursty = 1'b0;
        // longest frame within the length limit, then one beyond it
        build_frame(255, 8'h10, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(258, 8'h10, FLAW_NONE, FILL_RANDOM);
        send_frame();
        await_idle();

        // equal foot and wheel lengths: foot takes precedence
        write_config(8'h00, 8'hFF, 8'hFF, 8'd8, 8'd8, 8'd0);
        bursty = 1'b1;
        build_frame(8, 8'h00, FLAW_NONE, FILL_RANDOM);
        send_frame();
        build_frame(8, 8'hFE, FLAW_SUM, FILL_RANDOM);
        send_frame();
        build_frame(8, 8'hFF, FLAW_NONE, FILL_RANDOM);
        send_frame();
        await_idle();
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        int unsigned thr;
        logic [7:0]  cmd;
        t_frame_flaw flaw;
        pick = $urandom_range(0, 99);
        thr  = cfg_model.update_command_threshold;
        flaw = FLAW_NONE;
        if (pick < 78) begin
            k = $urandom_range(0, 2);
            if (thr == 0) k = 2;
            if (k == 2) begin
                len = cfg_model.update_frame_length;
                cmd = 8'($urandom_range(thr, 255));
            end else begin
                len = (k == 0) ? cfg_model.foot_frame_length : cfg_model.wheel_frame_length;
                cmd = 8'($urandom_range(0, thr - 1));
            end
            // keep most frames short
            if (len < MinFrameLen || (len > 40 && $urandom_range(0, 9) != 0))
                len = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0: flaw = FLAW_HEAD;
                1: flaw = FLAW_FOOT;
                2: flaw = FLAW_SUM;
                default: flaw = FLAW_NONE;
            endcase
        end else if (pick < 99) begin
            len  = $urandom_range(1, 24);
            cmd  = 8'($urandom);
            flaw = t_frame_flaw'($urandom_range(0, 3));
        end else begin
            len = $urandom_range(256, 262);
            cmd = 8'($urandom);
        end
        build_frame(len, cmd, flaw, FILL_RANDOM);
        if (pick >= 78 && $urandom_range(0, 1) == 0) frame_buf[0] = 8'($urandom);
        bursty = ($urandom_range(0, 3) != 0);
        send_frame();
        // now and then hold off until every verdict is back
        if ($urandom_range(0, 11) == 0) await_results();
    endtask

    task automatic test_random_phase(input logic [7:0] hdr, input logic [7:0] ftr,
                                     input logic [7:0] thr, input logic [7:0] foot,
                                     input logic [7:0] wheel, input logic [7:0] upd);
        int unsigned start;
        write_config(hdr, ftr, thr, foot, wheel, upd);
        start = bytes_sent;
        while (bytes_sent - start < PhaseBytes) random_frame();
        await_idle();
    endtask

    task automatic test_random_frames();
        logic [7:0] len_a;
        test_random_phase(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom_range(6, 20)), 8'($urandom_range(6, 20)),
                          8'($urandom_range(6, 20)));
        test_random_phase(8'h00, 8'hFF, 8'h00, 8'd0, 8'd0, 8'd6);
        len_a = 8'($urandom_range(6, 16));
        test_random_phase(8'($urandom), 8'($urandom), 8'hFF, len_a, len_a,
                          8'($urandom_range(6, 16)));
        test_random_phase(8'hFF, 8'h00, 8'($urandom_range(1, 254)),
                          8'($urandom_range(6, 12)), 8'($urandom_range(13, 20)),
                          8'($urandom_range(6, 20)));
        test_random_phase(8'($urandom), 8'($urandom), 8'hFF, 8'd5, 8'd7, 8'd255);
    endtask

    // result channel: check each accepted verdict and draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict: kind %0d verdict %0d sum %08h",
                                 frame_kind, verdict, computed_sum);
                end else begin
                    want_res = expected_verdicts.pop_front();
                    if (frame_kind !== want_res.frame_kind || verdict !== want_res.verdict ||
                        computed_sum !== want_res.computed_sum) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: kind %0d/%0d verdict %0d/%0d sum %08h/%08h",
                                     want_res.frame_kind, frame_kind, want_res.verdict,
                                     verdict, want_res.computed_sum, computed_sum);
                    end
                end
                stall_left = bursty ? $urandom_range(0, 19) : 0;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        cfg_model.header_value             = 8'h00;
        cfg_model.footer_value             = 8'h00;
        cfg_model.update_command_threshold = 8'hFF;
        cfg_model.foot_frame_length        = 8'h00;
        cfg_model.wheel_frame_length       = 8'h00;
        cfg_model.update_frame_length      = 8'h00;
        clear_frame_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_frames();
        test_random_frames();

        await_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
